// ===== hdl/ple_pkg.sv =====
// Package of the punishment leader elector: shared constants, operation and
// register codes, and the structures passed between the top level and the cells.
// Depends on nothing.
package ple_pkg;

	localparam int NODE_COUNT_DEF = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int LEADER_LIMIT   = 999;
	localparam int NODE_BITS      = 4;
	localparam int TIME_BITS      = 16;

	localparam logic [1:0] OP_ALIVE  = 2'd0;
	localparam logic [1:0] OP_EXPIRE = 2'd1;
	localparam logic [1:0] OP_START  = 2'd2;
	localparam logic [1:0] OP_STOP   = 2'd3;

	localparam logic [1:0] REG_OWN_NODE  = 2'd0;
	localparam logic [1:0] REG_INIT_TIME = 2'd1;
	localparam logic [1:0] REG_TIME_STEP = 2'd2;
	localparam logic [1:0] REG_FAULTY    = 2'd3;

	typedef struct packed {
		logic                 upd;
		logic                 alive;
		logic                 expire;
		logic [NODE_BITS-1:0] src;
		logic [NODE_BITS-1:0] own;
		logic                 knows;
		logic [TIME_BITS-1:0] init_time;
		logic [TIME_BITS-1:0] step;
	} ple_cmd_t;

	typedef struct packed {
		logic                 tok;
		logic                 found;
		logic [TIME_BITS-1:0] delay;
	} ple_scan_t;

endpackage

// ===== hdl/ple_cell.sv =====
// One table entry of the punishment leader elector: presence, timeout, punishment
// state and count, plus its registered stage of the leader scan chain.
// Depends on ple_pkg.
module ple_cell
	import ple_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int ID         = 0,
	localparam int IW        = $clog2(NODE_COUNT),
	localparam int BW        = (COUNT_BITS > 10) ? COUNT_BITS : 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ple_cmd_t              cmd,
	input  logic [COUNT_BITS-1:0] scount,
	input  ple_scan_t             scan_in,
	input  logic [BW-1:0]         best_in,
	input  logic [IW-1:0]         who_in,
	output ple_scan_t             scan_out,
	output logic [BW-1:0]         best_out,
	output logic [IW-1:0]         who_out
);

	logic                  heard_q;
	logic                  punished_q;
	logic [TIME_BITS-1:0]  time_q;
	logic [COUNT_BITS-1:0] count_q;

	logic                  heard_d;
	logic                  punished_d;
	logic [TIME_BITS-1:0]  time_d;
	logic [COUNT_BITS-1:0] count_d;
	logic [TIME_BITS:0]    time_sum;
	logic                  hit;
	logic                  own_hit;
	logic                  take;

	logic                  tok_q;
	logic                  found_q;
	logic [TIME_BITS-1:0]  delay_q;
	logic [BW-1:0]         best_q;
	logic [IW-1:0]         who_q;

	assign hit      = (32'(cmd.src) == ID);
	assign own_hit  = (32'(cmd.own) == ID);
	assign time_sum = {1'b0, time_q} + {1'b0, cmd.step};

	always_comb begin
		heard_d    = heard_q;
		punished_d = punished_q;
		time_d     = time_q;
		count_d    = count_q;
		if (cmd.alive && hit) begin
			if (!heard_d) begin
				heard_d = 1'b1;
				time_d  = cmd.init_time;
			end
			if (punished_d) begin
				if (scount > count_d) begin
					count_d = scount;
				end
			end else begin
				punished_d = 1'b1;
				count_d    = scount;
			end
		end
		if (cmd.alive && own_hit && !cmd.knows) begin
			if (!punished_d) begin
				punished_d = 1'b1;
				count_d    = '0;
			end
			if (count_d != '1) begin
				count_d = count_d + 1'b1;
			end
		end
		if (cmd.expire && hit) begin
			if (heard_q) begin
				time_d = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];
			end
			punished_d = 1'b0;
			count_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heard_q    <= (ID == 0);
			punished_q <= (ID == 0);
			time_q     <= '0;
			count_q    <= '0;
		end else if (cmd.upd) begin
			heard_q    <= heard_d;
			punished_q <= punished_d;
			time_q     <= time_d;
			count_q    <= count_d;
		end
	end

	assign take = punished_q && (BW'(count_q) <= best_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= scan_in.tok;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_in.tok) begin
			found_q <= scan_in.found | take;
			delay_q <= (cmd.alive && hit) ? time_q : scan_in.delay;
			best_q  <= take ? BW'(count_q) : best_in;
			who_q   <= take ? IW'(ID) : who_in;
		end
	end

	assign scan_out.tok   = tok_q;
	assign scan_out.found = found_q;
	assign scan_out.delay = delay_q;
	assign best_out       = best_q;
	assign who_out        = who_q;

endmodule

// ===== hdl/punishment_leader_elector.sv =====
// Top level of the punishment leader elector: configuration registers, item
// sequencing, the chain of node cells and the result register.
// Depends on ple_pkg and ple_cell.
//
// Each transaction passes through these steps from acceptance to the result
// being offered: the addressed table entries are updated, the scan token passes
// down the chain of cells one cell per cycle (carrying the best count, its node
// and the timer delay), the leader is settled and the result register is loaded.
// A new transaction is accepted once the previous one has reached the result
// register, even if that result has not been taken yet. Loading the result
// register waits while an earlier result is still offered and not yet taken.
module punishment_leader_elector
	import ple_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  logic [NODE_BITS-1:0] source_node,
	input  logic [15:0]          sender_count,
	input  logic                 sender_knows_me,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 leader_changed,
	output logic [NODE_BITS-1:0] leader_node,
	output logic                 arm_timer,
	output logic [TIME_BITS-1:0] timer_delay
);

	localparam int IW = $clog2(NODE_COUNT);
	localparam int BW = (COUNT_BITS > 10) ? COUNT_BITS : 10;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [NODE_BITS-1:0]  own_q;
	logic [TIME_BITS-1:0]  init_time_q;
	logic [TIME_BITS-1:0]  step_q;
	logic                  faulty_q;

	logic [2:0]            state_q;
	logic [1:0]            op_q;
	logic [NODE_BITS-1:0]  src_q;
	logic [15:0]           scount_q;
	logic                  knows_q;
	logic                  act_q;
	logic                  arm_q;
	logic                  running_q;
	logic                  ended_q;
	logic [NODE_BITS-1:0]  leader_q;
	logic [NODE_BITS-1:0]  rep_q;
	logic                  rep_valid_q;
	logic                  res_changed_q;
	logic [TIME_BITS-1:0]  res_delay_q;

	logic                  out_valid_q;
	logic                  changed_q;
	logic [NODE_BITS-1:0]  leader_out_q;
	logic                  arm_out_q;
	logic [TIME_BITS-1:0]  delay_out_q;

	logic                  cfg_wr;
	logic                  in_take;
	logic                  alive_ok;
	logic [COUNT_BITS-1:0] scount_clip;
	logic [NODE_BITS-1:0]  new_leader;
	logic                  new_changed;
	ple_cmd_t              cmd;

	ple_scan_t             scan_link [NODE_COUNT+1];
	logic [BW-1:0]         best_link [NODE_COUNT+1];
	logic [IW-1:0]         who_link  [NODE_COUNT+1];

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q       <= '0;
			init_time_q <= TIME_BITS'(100);
			step_q      <= TIME_BITS'(10);
			faulty_q    <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_OWN_NODE:  own_q       <= pwdata[NODE_BITS-1:0];
				REG_INIT_TIME: init_time_q <= pwdata[TIME_BITS-1:0];
				REG_TIME_STEP: step_q      <= pwdata[TIME_BITS-1:0];
				REG_FAULTY:    faulty_q    <= pwdata[0];
				default:       own_q       <= own_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_OWN_NODE:  prdata = 32'(own_q);
			REG_INIT_TIME: prdata = 32'(init_time_q);
			REG_TIME_STEP: prdata = 32'(step_q);
			REG_FAULTY:    prdata = 32'(faulty_q);
			default:       prdata = '0;
		endcase
	end

	// Item sequencing.
	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;
	assign alive_ok = (op_q == OP_ALIVE) && running_q && !ended_q && !faulty_q;

	assign scount_clip = (32'(scount_q) > 32'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(scount_q);

	always_comb begin
		cmd.upd       = (state_q == ST_UPD);
		cmd.alive     = alive_ok;
		cmd.expire    = (op_q == OP_EXPIRE);
		cmd.src       = src_q;
		cmd.own       = own_q;
		cmd.knows     = knows_q;
		cmd.init_time = init_time_q;
		cmd.step      = step_q;
	end

	assign new_leader  = (act_q && scan_link[NODE_COUNT].found) ?
		NODE_BITS'(who_link[NODE_COUNT]) : leader_q;
	assign new_changed = act_q && running_q && !ended_q &&
		!(rep_valid_q && (rep_q == new_leader));

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q     <= operation;
			src_q    <= source_node;
			scount_q <= sender_count;
			knows_q  <= sender_knows_me;
		end
		if (state_q == ST_UPD) begin
			act_q <= alive_ok || (op_q == OP_EXPIRE);
			arm_q <= alive_ok && (32'(src_q) < NODE_COUNT);
		end
		if (state_q == ST_WAIT && scan_link[NODE_COUNT].tok) begin
			res_changed_q <= new_changed;
			res_delay_q   <= scan_link[NODE_COUNT].delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			ended_q     <= 1'b0;
			leader_q    <= '0;
			rep_q       <= '0;
			rep_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (op_q == OP_START) begin
						running_q <= 1'b1;
					end
					if (op_q == OP_STOP) begin
						ended_q <= 1'b1;
					end
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (scan_link[NODE_COUNT].tok) begin
						leader_q <= new_leader;
						if (new_changed) begin
							rep_q       <= new_leader;
							rep_valid_q <= 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan chain of node cells.
	assign scan_link[0].tok   = (state_q == ST_SCAN);
	assign scan_link[0].found = 1'b0;
	assign scan_link[0].delay = '0;
	assign best_link[0]       = BW'(LEADER_LIMIT);
	assign who_link[0]        = '0;

	for (genvar i = 0; i < NODE_COUNT; i++) begin : g_cell
		ple_cell #(
			.NODE_COUNT (NODE_COUNT),
			.COUNT_BITS (COUNT_BITS),
			.ID         (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.scount   (scount_clip),
			.scan_in  (scan_link[i]),
			.best_in  (best_link[i]),
			.who_in   (who_link[i]),
			.scan_out (scan_link[i+1]),
			.best_out (best_link[i+1]),
			.who_out  (who_link[i+1])
		);
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			changed_q    <= res_changed_q;
			leader_out_q <= leader_q;
			arm_out_q    <= arm_q;
			delay_out_q  <= res_delay_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign leader_changed = changed_q;
	assign leader_node    = leader_out_q;
	assign arm_timer      = arm_out_q;
	assign timer_delay    = delay_out_q;

endmodule
